/* hdl/ipv4_receive_header_check_top_macros.svh */
// ----------------------------------------------------------------------------
// IPv4 receive header check - assertion macros
// Concurrent check helpers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IPV4_RECEIVE_HEADER_CHECK_TOP_MACROS_SVH
`define IPV4_RECEIVE_HEADER_CHECK_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define IPV4RHC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipv4rhc check failed");
// next-cycle implication
`define IPV4RHC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipv4rhc check failed");
`else
`define IPV4RHC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IPV4RHC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hdl/ipv4rhc_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header check - package
// Shared constants, verdict codes and the per-packet summary record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4rhc_pkg;

   localparam int QUEUE_DEPTH    = 4;
   localparam int RSP_DATA_WIDTH = 104;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
   localparam logic [3:0]  HDR_VERSION_IPV4 = 4'd4;
   localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;
   localparam logic [15:0] POS_MAX          = 16'hFFFF;
   localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;
   localparam logic [7:0]  PROTO_ICMP       = 8'd1;
   localparam logic [7:0]  PROTO_TCP        = 8'd6;
   localparam logic [7:0]  PROTO_UDP        = 8'd17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOCAL_ADDRESS     = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERFACE_PRESENT = 1'b1;

   typedef enum logic [3:0] {
      VERDICT_ICMP      = 4'd0,
      VERDICT_TCP       = 4'd1,
      VERDICT_UDP       = 4'd2,
      VERDICT_UNKNOWN   = 4'd3,
      VERDICT_SHORT     = 4'd4,
      VERDICT_VERSION   = 4'd5,
      VERDICT_HDR_LEN   = 4'd6,
      VERDICT_TOTAL_LEN = 4'd7,
      VERDICT_CHECKSUM  = 4'd8,
      VERDICT_NOT_MINE  = 4'd9,
      VERDICT_NO_IFACE  = 4'd10
   } verdict_type;

   // everything the back end needs to judge one finished packet
   typedef struct packed {
      logic [7:0]  ver_ihl;
      logic [15:0] dgram_len;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] csum;
      logic [15:0] pkt_len;
   } pkt_summary_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [31:0] local_addr;
      logic        iface_present;
   } cfg_type;

endpackage

/* hdl/ipv4_receive_header_check_top.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header check - top level
// Byte-stream IPv4 header validation with one verdict beat per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per clock on the req_ stream (tlast marks
// the final byte) and returns one verdict beat per packet on the rsp_ stream;
// rsp_tvalid rises once the summary has passed the queue into the verdict
// output register. Byte capture and the running ones-complement header sum keep
// pace in the front end, so the sustained rate is one byte per clock with no gap
// between packets while the queue is not full. Summaries of finished packets
// wait in a QUEUE_DEPTH-entry queue in front of the verdict stage; req_tready
// drops only when that queue is full, which takes a stall on the rsp_ side.
// The user writes configuration via csr_ while idle; the block does not check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_receive_header_check_top #(
   parameter int QUEUE_DEPTH = ipv4rhc_pkg::QUEUE_DEPTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // tdata: data_byte[7:0]
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,
   input  logic                                      req_tlast,
   // tdata: verdict[3:0], source_address[35:4], destination_address[67:36],
   //        protocol_number[75:68], header_bytes[81:76], payload_length[97:82]
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [ipv4rhc_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   input  logic                                      csr_we,
   input  logic [ipv4rhc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                               csr_data
);

   ipv4rhc_pkg::cfg_type          cfg_ff;
   ipv4rhc_pkg::queue_status_type q_status;
   ipv4rhc_pkg::pkt_summary_type  push_data;
   ipv4rhc_pkg::pkt_summary_type  pop_data;
   logic                          q_push;
   logic                          q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ipv4rhc_pkg::CSR_LOCAL_ADDRESS:     cfg_ff.local_addr    <= csr_data;
            ipv4rhc_pkg::CSR_INTERFACE_PRESENT: cfg_ff.iface_present <= csr_data[0];
            default: ;
         endcase
      end
   end

   ipv4rhc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_byte    (req_tdata),
      .req_last    (req_tlast),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (push_data)
   );

   ipv4rhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   ipv4rhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .q_data     (pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hdl/ipv4rhc_front.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header check - front end
// Takes packet bytes, captures header fields, keeps the running header
// checksum and pushes a summary record on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_receive_header_check_top_macros.svh"

module ipv4rhc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_byte,
   input  logic                         req_last,
   input  ipv4rhc_pkg::queue_status_type q_status,
   output logic                         q_push,
   output ipv4rhc_pkg::pkt_summary_type q_push_data
);

   logic [15:0] pos_ff,     pos_in;
   logic [7:0]  ver_ihl_ff, ver_ihl_in;
   logic [15:0] total_ff,   total_in;
   logic [7:0]  proto_ff,   proto_in;
   logic [31:0] src_ff,     src_in;
   logic [31:0] dst_ff,     dst_in;
   logic [15:0] csum_ff,    csum_in;
   logic [7:0]  pend_ff,    pend_in;

   logic        beat;
   logic [5:0]  hdr_bytes;
   logic [16:0] csum_sum;
   logic [15:0] csum_add;
   logic [15:0] pkt_len;

   assign req_tready = !q_status.full;
   assign beat       = req_tvalid && req_tready;

   always_comb begin
      ver_ihl_in = ver_ihl_ff;
      total_in   = total_ff;
      proto_in   = proto_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      priority if (pos_ff == 16'd0) begin
         ver_ihl_in = req_byte;
      end else if (pos_ff == 16'd2) begin
         total_in = {req_byte, total_ff[7:0]};
      end else if (pos_ff == 16'd3) begin
         total_in = {total_ff[15:8], req_byte};
      end else if (pos_ff == 16'd9) begin
         proto_in = req_byte;
      end else if (pos_ff >= 16'd12 && pos_ff <= 16'd15) begin
         src_in = {src_ff[23:0], req_byte};
      end else if (pos_ff >= 16'd16 && pos_ff <= 16'd19) begin
         dst_in = {dst_ff[23:0], req_byte};
      end else begin
         // nothing captured from the other bytes
      end

      // IHL taken from this beat when it is the first byte
      hdr_bytes = {ver_ihl_in[3:0], 2'b00};

      // ones-complement add with end-around carry; low half can't overflow
      csum_sum = {1'b0, csum_ff} + {1'b0, pend_ff, req_byte};
      csum_add = csum_sum[16] ? (csum_sum[15:0] + 16'd1) : csum_sum[15:0];

      pend_in = pend_ff;
      csum_in = csum_ff;
      if (pos_ff < {10'd0, hdr_bytes}) begin
         if (!pos_ff[0]) begin
            pend_in = req_byte;
         end else begin
            csum_in = csum_add;
         end
      end

      pos_in  = (pos_ff < ipv4rhc_pkg::POS_MAX) ? pos_ff + 16'd1 : pos_ff;
      pkt_len = pos_in;

      q_push_data.ver_ihl   = ver_ihl_in;
      q_push_data.dgram_len = total_in;
      q_push_data.protocol  = proto_in;
      q_push_data.src_addr  = src_in;
      q_push_data.dst_addr  = dst_in;
      q_push_data.csum      = csum_in;
      q_push_data.pkt_len   = pkt_len;
   end

   assign q_push = beat && req_last;

   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         pos_ff     <= '0;
         ver_ihl_ff <= '0;
         total_ff   <= '0;
         proto_ff   <= '0;
         src_ff     <= '0;
         dst_ff     <= '0;
         csum_ff    <= '0;
         pend_ff    <= '0;
      end else if (beat) begin
         pos_ff     <= pos_in;
         ver_ihl_ff <= ver_ihl_in;
         total_ff   <= total_in;
         proto_ff   <= proto_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         csum_ff    <= csum_in;
         pend_ff    <= pend_in;
      end
   end

   `IPV4RHC_ASSERT_NXT(a_front_clear, clock, reset, q_push, pos_ff == 16'd0 && csum_ff == 16'd0)

endmodule

/* hdl/ipv4rhc_queue.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header check - summary queue
// Small register FIFO between front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_receive_header_check_top_macros.svh"

module ipv4rhc_queue #(
   parameter int DEPTH = ipv4rhc_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ipv4rhc_pkg::pkt_summary_type  push_data,
   input  logic                          pop,
   output ipv4rhc_pkg::pkt_summary_type  pop_data,
   output ipv4rhc_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   ipv4rhc_pkg::pkt_summary_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `IPV4RHC_ASSERT_IMP(a_queue_no_overflow, clock, reset, status.full, !push)
   `IPV4RHC_ASSERT_IMP(a_queue_no_underflow, clock, reset, status.empty, !pop)

endmodule

/* hdl/ipv4rhc_back.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header check - back end
// Judges one packet summary per cycle while the output register is free or
// being taken, and holds the verdict beat there until the result side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_receive_header_check_top_macros.svh"

module ipv4rhc_back (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ipv4rhc_pkg::cfg_type                      cfg,
   input  ipv4rhc_pkg::queue_status_type             q_status,
   input  ipv4rhc_pkg::pkt_summary_type              q_data,
   output logic                                      q_pop,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [ipv4rhc_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata
);

   logic                     valid_ff;
   ipv4rhc_pkg::verdict_type verdict_ff, verdict_in;
   logic [31:0]              src_ff;
   logic [31:0]              dst_ff;
   logic [7:0]               proto_ff;
   logic [5:0]               hdr_ff,     hdr_in;
   logic [15:0]              payload_ff, payload_in;

   logic [15:0]              hdr_wide;
   logic                     drop_beat;

   assign q_pop = !q_status.empty && (!valid_ff || rsp_tready);

   always_comb begin
      hdr_in     = {q_data.ver_ihl[3:0], 2'b00};
      hdr_wide   = {10'd0, hdr_in};
      payload_in = '0;
      priority if (q_data.pkt_len < ipv4rhc_pkg::MIN_HEADER_BYTES) begin
         verdict_in = ipv4rhc_pkg::VERDICT_SHORT;
      end else if (q_data.ver_ihl[7:4] != ipv4rhc_pkg::HDR_VERSION_IPV4) begin
         verdict_in = ipv4rhc_pkg::VERDICT_VERSION;
      end else if (hdr_wide < ipv4rhc_pkg::MIN_HEADER_BYTES || hdr_wide > q_data.pkt_len) begin
         verdict_in = ipv4rhc_pkg::VERDICT_HDR_LEN;
      end else if (q_data.dgram_len > q_data.pkt_len || q_data.dgram_len < hdr_wide) begin
         verdict_in = ipv4rhc_pkg::VERDICT_TOTAL_LEN;
      end else if (q_data.csum != ipv4rhc_pkg::CSUM_GOOD) begin
         verdict_in = ipv4rhc_pkg::VERDICT_CHECKSUM;
      end else if (q_data.dst_addr != cfg.local_addr
                   && q_data.dst_addr != ipv4rhc_pkg::BROADCAST_ADDR) begin
         verdict_in = ipv4rhc_pkg::VERDICT_NOT_MINE;
      end else if (!cfg.iface_present) begin
         verdict_in = ipv4rhc_pkg::VERDICT_NO_IFACE;
      end else begin
         payload_in = q_data.dgram_len - hdr_wide;
         priority if (q_data.protocol == ipv4rhc_pkg::PROTO_ICMP) begin
            verdict_in = ipv4rhc_pkg::VERDICT_ICMP;
         end else if (q_data.protocol == ipv4rhc_pkg::PROTO_TCP) begin
            verdict_in = ipv4rhc_pkg::VERDICT_TCP;
         end else if (q_data.protocol == ipv4rhc_pkg::PROTO_UDP) begin
            verdict_in = ipv4rhc_pkg::VERDICT_UDP;
         end else begin
            verdict_in = ipv4rhc_pkg::VERDICT_UNKNOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         verdict_ff <= verdict_in;
         src_ff     <= q_data.src_addr;
         dst_ff     <= q_data.dst_addr;
         proto_ff   <= q_data.protocol;
         hdr_ff     <= hdr_in;
         payload_ff <= payload_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, payload_ff, hdr_ff, proto_ff, dst_ff, src_ff, verdict_ff};

   assign drop_beat = valid_ff && (verdict_ff >= ipv4rhc_pkg::VERDICT_SHORT);

   `IPV4RHC_ASSERT_IMP(a_back_drop_no_payload, clock, reset, drop_beat, payload_ff == 16'd0)

endmodule

/* tb/header_verdict_checker.sv */
// ----------------------------------------------------------------------------
// IPv4 header verdict checker
// Watches the byte stream, the verdict stream and the csr port. Keeps its
// own model of the header check, queues the verdict due for every packet
// and compares each verdict beat against the oldest one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module header_verdict_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   input  logic [7:0]                              req_tdata,
   input  logic                                    req_tlast,
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic [ipv4rhc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                    csr_we,
   input  logic [ipv4rhc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                             csr_data,
   output int                                      mismatches,
   output int                                      outstanding
);

   // verdict beat layout, lowest field last
   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] payload_length;
      logic [5:0]  header_bytes;
      logic [7:0]  protocol_number;
      logic [31:0] destination_address;
      logic [31:0] source_address;
      logic [3:0]  verdict;
   } verdict_beat_type;

   logic [31:0]      local_addr_cfg;
   logic             iface_cfg;

   logic [15:0]      pos;
   logic [7:0]       ver_ihl;
   logic [15:0]      dgram_len;
   logic [7:0]       proto;
   logic [31:0]      src;
   logic [31:0]      dst;
   logic [15:0]      csum;
   logic [7:0]       hi_byte;

   verdict_beat_type verdicts_due[$];
   int               beat_no;

   function automatic logic [15:0] ones_sum(input logic [15:0] acc,
                                            input logic [15:0] word);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, word};
      return s[16] ? s[15:0] + 16'd1 : s[15:0];
   endfunction

   task automatic clear_packet();
      pos       = '0;
      ver_ihl   = '0;
      dgram_len = '0;
      proto     = '0;
      src       = '0;
      dst       = '0;
      csum      = '0;
      hi_byte   = '0;
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // one byte of the packet; on the marked byte, queue the verdict due
   task automatic absorb_byte(input logic [7:0] b, input logic last);
      logic [5:0]       hdr;
      logic [15:0]      hdr16;
      logic [15:0]      len;
      verdict_beat_type v;
      if (pos == 16'd0) ver_ihl = b;
      else if (pos == 16'd2) dgram_len[15:8] = b;
      else if (pos == 16'd3) dgram_len[7:0] = b;
      else if (pos == 16'd9) proto = b;
      else if (pos >= 16'd12 && pos <= 16'd15) src = {src[23:0], b};
      else if (pos >= 16'd16 && pos <= 16'd19) dst = {dst[23:0], b};

      hdr   = {ver_ihl[3:0], 2'b00};
      hdr16 = {10'd0, hdr};
      if (pos < hdr16) begin
         if (!pos[0]) hi_byte = b;
         else csum = ones_sum(csum, {hi_byte, b});
      end

      if (!last) begin
         if (pos < ipv4rhc_pkg::POS_MAX) pos = pos + 16'd1;
         return;
      end

      len = (pos < ipv4rhc_pkg::POS_MAX) ? pos + 16'd1 : ipv4rhc_pkg::POS_MAX;
      v = '0;
      v.source_address      = src;
      v.destination_address = dst;
      v.protocol_number     = proto;
      v.header_bytes        = hdr;
      if (len < ipv4rhc_pkg::MIN_HEADER_BYTES)
         v.verdict = ipv4rhc_pkg::VERDICT_SHORT;
      else if (ver_ihl[7:4] != ipv4rhc_pkg::HDR_VERSION_IPV4)
         v.verdict = ipv4rhc_pkg::VERDICT_VERSION;
      else if (hdr16 < ipv4rhc_pkg::MIN_HEADER_BYTES || hdr16 > len)
         v.verdict = ipv4rhc_pkg::VERDICT_HDR_LEN;
      else if (dgram_len > len || dgram_len < hdr16)
         v.verdict = ipv4rhc_pkg::VERDICT_TOTAL_LEN;
      else if (csum != ipv4rhc_pkg::CSUM_GOOD)
         v.verdict = ipv4rhc_pkg::VERDICT_CHECKSUM;
      else if (dst != local_addr_cfg && dst != ipv4rhc_pkg::BROADCAST_ADDR)
         v.verdict = ipv4rhc_pkg::VERDICT_NOT_MINE;
      else if (!iface_cfg)
         v.verdict = ipv4rhc_pkg::VERDICT_NO_IFACE;
      else begin
         v.payload_length = dgram_len - hdr16;
         case (proto)
            ipv4rhc_pkg::PROTO_ICMP: v.verdict = ipv4rhc_pkg::VERDICT_ICMP;
            ipv4rhc_pkg::PROTO_TCP:  v.verdict = ipv4rhc_pkg::VERDICT_TCP;
            ipv4rhc_pkg::PROTO_UDP:  v.verdict = ipv4rhc_pkg::VERDICT_UDP;
            default:                 v.verdict = ipv4rhc_pkg::VERDICT_UNKNOWN;
         endcase
      end
      verdicts_due.push_back(v);
      clear_packet();
   endtask

   task automatic compare_beat(input verdict_beat_type got, input verdict_beat_type want);
      if (got.verdict !== want.verdict)
         report_mismatch($sformatf("beat %0d verdict %0d, want %0d",
            beat_no, got.verdict, want.verdict));
      if (got.source_address !== want.source_address)
         report_mismatch($sformatf("beat %0d source %h, want %h",
            beat_no, got.source_address, want.source_address));
      if (got.destination_address !== want.destination_address)
         report_mismatch($sformatf("beat %0d destination %h, want %h",
            beat_no, got.destination_address, want.destination_address));
      if (got.protocol_number !== want.protocol_number)
         report_mismatch($sformatf("beat %0d protocol %0d, want %0d",
            beat_no, got.protocol_number, want.protocol_number));
      if (got.header_bytes !== want.header_bytes)
         report_mismatch($sformatf("beat %0d header bytes %0d, want %0d",
            beat_no, got.header_bytes, want.header_bytes));
      if (got.payload_length !== want.payload_length)
         report_mismatch($sformatf("beat %0d payload %0d, want %0d",
            beat_no, got.payload_length, want.payload_length));
      if (got.pad !== want.pad)
         report_mismatch($sformatf("beat %0d pad bits %b not zero", beat_no, got.pad));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         local_addr_cfg = '0;
         iface_cfg      = 1'b0;
         clear_packet();
         verdicts_due.delete();
         mismatches = 0;
         beat_no    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ipv4rhc_pkg::CSR_LOCAL_ADDRESS:     local_addr_cfg = csr_data;
               ipv4rhc_pkg::CSR_INTERFACE_PRESENT: iface_cfg = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            absorb_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0)
               report_mismatch($sformatf("beat %0d arrived with no packet pending", beat_no));
            else
               compare_beat(verdict_beat_type'(rsp_tdata), verdicts_due.pop_front());
            beat_no++;
         end
      end
      outstanding <= verdicts_due.size();
   end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header check testbench
// Streams IPv4 packets byte by byte into the header check: a directed set
// covering each verdict save NO_IFACE, and the length corner cases, then random
// packets, mostly well-formed with random content, over several csr settings.
// Both stream sides idle at random; the verdict side also holds off for a long
// stretch. The checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   typedef enum int {
      PK_GOOD,
      PK_BCAST,
      PK_BAD_VERSION,
      PK_IHL_SMALL,
      PK_HDR_BEYOND,
      PK_TOTAL_BEYOND,
      PK_TOTAL_BELOW,
      PK_BAD_CSUM,
      PK_FOREIGN,
      PK_SHORT,
      PK_NOISE,
      PK_ZERO
   } pkt_kind_type;

   logic                                    clock      = 1'b0;
   logic                                    reset      = 1'b1;
   logic                                    req_tvalid = 1'b0;
   logic                                    req_tready;
   logic [7:0]                              req_tdata  = '0;
   logic                                    req_tlast  = 1'b0;
   logic                                    rsp_tvalid;
   logic                                    rsp_tready = 1'b0;
   logic [ipv4rhc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                    csr_we     = 1'b0;
   logic [ipv4rhc_pkg::CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [31:0]                             csr_data   = '0;

   logic        steady     = 1'b0;
   logic        hold_off   = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left  = 0;
   int          mismatches;
   int          outstanding;
   logic [31:0] cur_local  = '0;
   logic [7:0]  pkt_bytes[$];

   ipv4_receive_header_check_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   header_verdict_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #6_000_000;
      $display("tb failed");
      $finish;
   end

   // verdict side: random back-pressure, plus one long hold-off once armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 24);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // build one packet of the given kind and stream it; a negative protocol,
   // a zero ihl or a zero length leaves that choice random
   task automatic send_packet(input pkt_kind_type kind, input int force_proto,
                              input int force_ihl, input int force_len);
      int          ihl;
      int          hdr_len;
      int          total;
      int          plen;
      int          cut;
      int          k;
      logic [7:0]  first;
      logic [31:0] dst;
      logic [15:0] sum;
      logic [16:0] s;
      pkt_bytes.delete();
      if (kind == PK_ZERO) begin
         repeat (20) pkt_bytes.push_back(8'h00);
      end else if (kind == PK_NOISE) begin
         plen = $urandom_range(1, 70);
         repeat (plen) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         ihl = (force_ihl > 0) ? force_ihl
               : ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(6, 15);
         hdr_len = 4 * ihl;
         total = hdr_len + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 24)
                                                         : $urandom_range(0, 4));
         plen = total + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0);
         repeat (plen) pkt_bytes.push_back(8'($urandom_range(0, 255)));

         first = {ipv4rhc_pkg::HDR_VERSION_IPV4, 4'(ihl)};
         case (kind)
            PK_BAD_VERSION:
               first[7:4] = 4'(ipv4rhc_pkg::HDR_VERSION_IPV4 + $urandom_range(1, 15));
            PK_IHL_SMALL:    first[3:0] = 4'($urandom_range(0, 4));
            PK_HDR_BEYOND:   first[3:0] = 4'($urandom_range(6, 15));
            PK_TOTAL_BEYOND: total = plen + $urandom_range(1, 400);
            PK_TOTAL_BELOW:  total = $urandom_range(0, hdr_len - 1);
            default: ;
         endcase
         pkt_bytes[0] = first;
         pkt_bytes[2] = 8'(total >> 8);
         pkt_bytes[3] = 8'(total);

         k = $urandom_range(0, 3);
         pkt_bytes[9] = (force_proto >= 0) ? 8'(force_proto)
                      : (k == 0) ? ipv4rhc_pkg::PROTO_ICMP
                      : (k == 1) ? ipv4rhc_pkg::PROTO_TCP
                      : (k == 2) ? ipv4rhc_pkg::PROTO_UDP : 8'($urandom_range(0, 255));
         dst = (kind == PK_BCAST) ? ipv4rhc_pkg::BROADCAST_ADDR
             : (kind == PK_FOREIGN) ? 32'($urandom()) : cur_local;
         for (int i = 0; i < 4; i++) pkt_bytes[16 + i] = dst[31 - 8 * i -: 8];

         pkt_bytes[10] = 8'h00;
         pkt_bytes[11] = 8'h00;
         sum = '0;
         for (int i = 0; i < hdr_len; i += 2) begin
            s   = {1'b0, sum} + {1'b0, pkt_bytes[i], pkt_bytes[i + 1]};
            sum = s[15:0] + {15'd0, s[16]};
         end
         pkt_bytes[10] = ~sum[15:8];
         pkt_bytes[11] = ~sum[7:0];

         case (kind)
            PK_BAD_CSUM: begin
               k = $urandom_range(4, hdr_len - 1);
               pkt_bytes[k] = pkt_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
            end
            PK_HDR_BEYOND: begin
               cut = 4 * first[3:0] - 1;
               if (cut > plen) cut = plen;
               cut = $urandom_range(20, cut);
               while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
            end
            PK_SHORT: begin
               cut = (force_len > 0) ? force_len : $urandom_range(1, 19);
               while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
            end
            default: ;
         endcase
      end
      foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
   endtask

   task automatic random_packets(input int byte_goal, input int packet_goal);
      int           sent_bytes;
      int           sent_pkts;
      int           r;
      pkt_kind_type kind;
      sent_bytes = 0;
      sent_pkts  = 0;
      while (sent_bytes < byte_goal || sent_pkts < packet_goal) begin
         r = $urandom_range(0, 99);
         kind = (r < 55) ? PK_GOOD : (r < 62) ? PK_BCAST : (r < 66) ? PK_BAD_VERSION
              : (r < 70) ? PK_IHL_SMALL : (r < 74) ? PK_HDR_BEYOND
              : (r < 78) ? PK_TOTAL_BEYOND : (r < 82) ? PK_TOTAL_BELOW
              : (r < 87) ? PK_BAD_CSUM : (r < 92) ? PK_FOREIGN
              : (r < 96) ? PK_SHORT : PK_NOISE;
         send_packet(kind, -1, 0, 0);
         sent_bytes += pkt_bytes.size();
         sent_pkts++;
      end
   endtask

   // stop offering bytes and wait out every pending verdict
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] addr, input logic present);
      cur_local = addr;
      csr_we    <= 1'b1;
      csr_index <= ipv4rhc_pkg::CSR_LOCAL_ADDRESS;
      csr_data  <= addr;
      @(posedge clock);
      csr_index <= ipv4rhc_pkg::CSR_INTERFACE_PRESENT;
      csr_data  <= {31'd0, present};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      @(negedge reset);
      @(posedge clock);

      // reset settings: no interface, address zero
      random_packets(40, 2);
      drain();

      set_config($urandom(), 1'b1);
      send_packet(PK_GOOD, ipv4rhc_pkg::PROTO_ICMP, 5, 0);
      send_packet(PK_GOOD, ipv4rhc_pkg::PROTO_TCP, 5, 0);
      send_packet(PK_GOOD, ipv4rhc_pkg::PROTO_UDP, 5, 0);
      send_packet(PK_GOOD, 0, 5, 0);
      send_packet(PK_GOOD, 255, 15, 0);
      send_packet(PK_BCAST, -1, 5, 0);
      send_packet(PK_SHORT, -1, 5, 1);
      send_packet(PK_SHORT, -1, 5, 19);
      send_packet(PK_ZERO, -1, 0, 0);
      send_packet(PK_BAD_VERSION, -1, 5, 0);
      send_packet(PK_IHL_SMALL, -1, 5, 0);
      send_packet(PK_HDR_BEYOND, -1, 5, 0);
      send_packet(PK_TOTAL_BEYOND, -1, 5, 0);
      send_packet(PK_TOTAL_BELOW, -1, 5, 0);
      send_packet(PK_BAD_CSUM, -1, 5, 0);
      send_packet(PK_FOREIGN, -1, 5, 0);
      drain();
      random_packets(150, 5);
      drain();

      set_config(32'h0000_0000, 1'b0);
      random_packets(200, 7);
      drain();

      // no idling on either side through this phase
      steady <= 1'b1;
      set_config(32'hFFFF_FFFF, 1'b1);
      random_packets(200, 7);
      drain();
      steady <= 1'b0;

      // verdict side holds off while short packets keep coming
      set_config($urandom(), 1'b1);
      hold_off <= 1'b1;
      repeat (8) send_packet(PK_GOOD, -1, 5, 0);
      random_packets(100, 4);
      drain();

      if (mismatches == 0 && outstanding == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/ipv4rhc_pkg.sv
hdl/ipv4rhc_front.sv
hdl/ipv4rhc_queue.sv
hdl/ipv4rhc_back.sv
hdl/ipv4_receive_header_check_top.sv
tb/header_verdict_checker.sv
tb/tb.sv
